/* hw/rtl/byte_frequency_ranker_macros.svh */
// Assertion macros shared by the byte frequency ranker RTL.
`ifndef BYTE_FREQUENCY_RANKER_MACROS_SVH
`define BYTE_FREQUENCY_RANKER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bfr_pkg.sv */
// Shared constants, operation codes and request/result types of the byte frequency ranker.
package bfr_pkg;

  localparam int DEFAULT_NUM_SYMBOLS = 256;
  localparam int CNT_W  = 32;
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] slot;
    logic [BYTE_W-1:0] symbol;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] symbol;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] rank;
  } result_t;

endpackage

/* hw/rtl/bfr_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered read data.
module bfr_ram #(
  parameter int WIDTH = bfr_pkg::CNT_W,
  parameter int DEPTH = bfr_pkg::DEFAULT_NUM_SYMBOLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bfr_seq.sv */
// Sequencer of the byte frequency ranker: table memories, shared count comparator and control.
`include "byte_frequency_ranker_macros.svh"

module bfr_seq #(
  parameter int NUM_SYMBOLS = bfr_pkg::DEFAULT_NUM_SYMBOLS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  bfr_pkg::cmd_t    cmd,
  output logic             busy,
  output bfr_pkg::result_t result
);

  localparam int SW = $clog2(NUM_SYMBOLS);
  localparam int CW = SW + 1;
  localparam int XW = ((SW > bfr_pkg::BYTE_W) ? SW : bfr_pkg::BYTE_W) + 1;
  localparam int EW = SW + bfr_pkg::CNT_W;
  localparam logic [CW-1:0] LAST   = CW'(NUM_SYMBOLS - 1);
  localparam logic [CW-1:0] NSYM   = CW'(NUM_SYMBOLS);
  localparam logic [XW-1:0] NSYM_X = XW'(NUM_SYMBOLS);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_GET_I = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_PLACE = 3'd6;
  localparam logic [2:0] ST_RANK  = 3'd7;

  logic [2:0]                st_r, st_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic [bfr_pkg::CNT_W-1:0] c_r, c_nxt;
  logic [SW-1:0]             s_r, s_nxt;
  bfr_pkg::cmd_t             cmd_r, cmd_nxt;

  logic          s_we, r_we;
  logic [SW-1:0] s_waddr, s_raddr, r_waddr, r_raddr;
  logic [EW-1:0] s_wdata, s_rdata, r_wdata, r_rdata;

  logic [SW-1:0]             s_rd_sym, r_rd_rank;
  logic [bfr_pkg::CNT_W-1:0] s_rd_cnt, r_rd_cnt;
  logic [XW-1:0]             s_rd_sym_x, r_rd_rank_x;
  logic [XW-1:0]             port_slot_x, port_sym_x, cmd_slot_x, cmd_sym_x;
  logic                      slot_ok, sym_ok, moves;
  logic [CW-1:0]             idx_m1, idx_p1, k_m1, k_m2;

  bfr_ram #(.WIDTH(EW), .DEPTH(NUM_SYMBOLS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bfr_ram #(.WIDTH(EW), .DEPTH(NUM_SYMBOLS)) u_rank_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  assign s_rd_sym    = s_rdata[EW-1 -: SW];
  assign s_rd_cnt    = s_rdata[bfr_pkg::CNT_W-1:0];
  assign r_rd_rank   = r_rdata[EW-1 -: SW];
  assign r_rd_cnt    = r_rdata[bfr_pkg::CNT_W-1:0];
  assign s_rd_sym_x  = XW'(s_rd_sym);
  assign r_rd_rank_x = XW'(r_rd_rank);
  assign port_slot_x = XW'(cmd.slot);
  assign port_sym_x  = XW'(cmd.symbol);
  assign cmd_slot_x  = XW'(cmd_r.slot);
  assign cmd_sym_x   = XW'(cmd_r.symbol);
  assign slot_ok     = cmd_slot_x < NSYM_X;
  assign sym_ok      = cmd_sym_x < NSYM_X;
  assign idx_m1      = idx_r - CW'(1);
  assign idx_p1      = idx_r + CW'(1);
  assign k_m1        = k_r - CW'(1);
  assign k_m2        = k_r - CW'(2);
  // The one shared count comparator: does the entry being inserted move past the one above?
  assign moves       = c_r > s_rd_cnt;
  assign busy        = st_r != ST_IDLE;

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    k_nxt   = k_r;
    c_nxt   = c_r;
    s_nxt   = s_r;
    cmd_nxt = cmd_r;
    s_we    = 1'b0;
    s_waddr = idx_r[SW-1:0];
    s_wdata = '0;
    s_raddr = idx_r[SW-1:0];
    r_we    = 1'b0;
    r_waddr = idx_r[SW-1:0];
    r_wdata = '0;
    r_raddr = idx_r[SW-1:0];
    result  = '0;
    result.rank = cmd_r.slot;

    case (st_r)
      ST_INIT: begin
        s_we    = 1'b1;
        s_wdata = {idx_r[SW-1:0], {bfr_pkg::CNT_W{1'b0}}};
        r_we    = 1'b1;
        r_wdata = {idx_r[SW-1:0], {bfr_pkg::CNT_W{1'b0}}};
        if (idx_r == LAST) begin
          st_nxt  = ST_IDLE;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      ST_IDLE: begin
        s_raddr = port_slot_x[SW-1:0];
        r_raddr = port_sym_x[SW-1:0];
        if (start) begin
          cmd_nxt = cmd;
          case (cmd.opcode)
            bfr_pkg::OP_CLEAR: begin
              st_nxt  = ST_CLEAR;
              idx_nxt = '0;
            end
            bfr_pkg::OP_WRITE, bfr_pkg::OP_READ, bfr_pkg::OP_LOOKUP: begin
              st_nxt = ST_ACC;
            end
            bfr_pkg::OP_SORT: begin
              s_raddr = SW'(1);
              idx_nxt = CW'(1);
              st_nxt  = ST_GET_I;
            end
            default: begin
              result.valid = 1'b1;
              result.rank  = cmd.slot;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_wdata = {idx_r[SW-1:0], {bfr_pkg::CNT_W{1'b0}}};
        if (idx_r == LAST) begin
          result.valid = 1'b1;
          st_nxt       = ST_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      ST_ACC: begin
        st_nxt       = ST_IDLE;
        result.valid = 1'b1;
        case (cmd_r.opcode)
          bfr_pkg::OP_WRITE: begin
            if (slot_ok) begin
              s_we          = 1'b1;
              s_waddr       = cmd_slot_x[SW-1:0];
              s_wdata       = {s_rd_sym, cmd_r.count};
              result.symbol = s_rd_sym_x[bfr_pkg::BYTE_W-1:0];
              result.count  = cmd_r.count;
            end
          end
          bfr_pkg::OP_READ: begin
            if (slot_ok) begin
              result.symbol = s_rd_sym_x[bfr_pkg::BYTE_W-1:0];
              result.count  = s_rd_cnt;
            end
          end
          bfr_pkg::OP_LOOKUP: begin
            result.symbol = cmd_r.symbol;
            result.rank   = '0;
            if (sym_ok) begin
              result.rank  = r_rd_rank_x[bfr_pkg::BYTE_W-1:0];
              result.count = r_rd_cnt;
            end
          end
          default: begin
            result.valid = 1'b1;
          end
        endcase
      end
      ST_GET_I: begin
        c_nxt   = s_rd_cnt;
        s_nxt   = s_rd_sym;
        k_nxt   = idx_r;
        s_raddr = idx_m1[SW-1:0];
        st_nxt  = ST_CMP;
      end
      ST_CMP: begin
        s_we    = 1'b1;
        s_waddr = k_r[SW-1:0];
        if (moves) begin
          s_wdata = s_rdata;
          k_nxt   = k_m1;
          if (k_m1 == '0) begin
            st_nxt = ST_PLACE;
          end else begin
            s_raddr = k_m2[SW-1:0];
          end
        end else begin
          s_wdata = {s_r, c_r};
          if (idx_r == LAST) begin
            st_nxt  = ST_RANK;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_p1;
            s_raddr = idx_p1[SW-1:0];
            st_nxt  = ST_GET_I;
          end
        end
      end
      ST_PLACE: begin
        s_we    = 1'b1;
        s_waddr = k_r[SW-1:0];
        s_wdata = {s_r, c_r};
        if (idx_r == LAST) begin
          st_nxt  = ST_RANK;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_p1;
          s_raddr = idx_p1[SW-1:0];
          st_nxt  = ST_GET_I;
        end
      end
      ST_RANK: begin
        // Slot idx is read while the slot before it is entered in the rank table.
        if (idx_r != '0) begin
          r_we    = 1'b1;
          r_waddr = s_rd_sym;
          r_wdata = {idx_m1[SW-1:0], s_rd_cnt};
        end
        if (idx_r == NSYM) begin
          result.valid = 1'b1;
          st_nxt       = ST_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_INIT;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
    cmd_r <= cmd_nxt;
  end

  `BFR_ASSERT_IMPL(a_cmp_above_top, st_r == ST_CMP, k_r != '0, "insertion step at slot zero")
  `BFR_ASSERT_NEXT(a_result_then_idle, result.valid, st_r == ST_IDLE, "result not followed by idle")
  `BFR_ASSERT_IMPL(a_no_result_init, st_r == ST_INIT, !result.valid, "result during clearing pass")
  `BFR_ASSERT_NEXT(a_sort_starts, st_r == ST_IDLE && start && cmd.opcode == bfr_pkg::OP_SORT, st_r == ST_GET_I, "sort did not start")

endmodule

/* hw/rtl/byte_frequency_ranker.sv */
// Top level of the byte frequency ranker: request port, sequencer and registered result port.

// A table of NUM_SYMBOLS slots, each holding a symbol and a 32-bit count, with an
// inverse map from symbol to rank built by each sort. A request is taken at a rising
// edge where start is high and busy is low; every request gives exactly one result,
// shown on the out_ ports for one cycle while out_valid is high. The receiver cannot
// hold results off, so it must take each one in the cycle it appears. An unused opcode
// is answered straight from idle; read, write and rank lookup pass through one access
// state; clear walks every slot; and sort is an insertion sort of S single-slot moves
// (at most NUM_SYMBOLS * (NUM_SYMBOLS - 1) / 2, about 32,600 for 256 symbols). Sort
// time is set by the single slot memory port pair: each move reads one slot and writes
// its neighbour, one move per cycle through one shared comparator, followed by a pass
// that fills the rank table. After reset the block runs a clearing pass over both
// tables and holds busy high until it ends.
module byte_frequency_ranker #(
  parameter int NUM_SYMBOLS = bfr_pkg::DEFAULT_NUM_SYMBOLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bfr_pkg::OP_W-1:0]    in_opcode,
  input  logic [bfr_pkg::BYTE_W-1:0]  in_slot,
  input  logic [bfr_pkg::BYTE_W-1:0]  in_symbol,
  input  logic [bfr_pkg::CNT_W-1:0]   in_count,
  output logic                        out_valid,
  output logic [bfr_pkg::BYTE_W-1:0]  out_symbol,
  output logic [bfr_pkg::CNT_W-1:0]   out_count,
  output logic [bfr_pkg::BYTE_W-1:0]  out_rank
);

  bfr_pkg::cmd_t    cmd;
  bfr_pkg::result_t result;

  logic                       out_valid_r;
  logic [bfr_pkg::BYTE_W-1:0] out_symbol_r;
  logic [bfr_pkg::CNT_W-1:0]  out_count_r;
  logic [bfr_pkg::BYTE_W-1:0] out_rank_r;

  // The request fields travel to the sequencer as one bundle; it samples them only
  // in the cycle in which it is idle and start is high.
  assign cmd.opcode = in_opcode;
  assign cmd.slot   = in_slot;
  assign cmd.symbol = in_symbol;
  assign cmd.count  = in_count;

  bfr_seq #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .result(result)
  );

  // The result is registered, so every output comes straight from a flip-flop and
  // the strobe lasts exactly one cycle. Only the strobe needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_symbol_r <= result.symbol;
      out_count_r  <= result.count;
      out_rank_r   <= result.rank;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_count  = out_count_r;
  assign out_rank   = out_rank_r;

endmodule
